// ===== sv/ssfa_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfa_pkg
// Shared types, widths, register codes and helpers of the sprite-sheet
// frame animator.
// ---------------------------------------------------------------------------
package ssfa_pkg;

	localparam int unsigned MAX_GRID_DEF    = 16;
	localparam int unsigned MAX_TEXTURE_DEF = 4096;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	// Register widths
	localparam int unsigned DIM_W    = 5;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned SPEED_W  = 16;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned FIRST_W  = 8;
	localparam int unsigned LAST_W   = 9;
	localparam int unsigned TEX_REG_W = 32;

	// Register reset values
	localparam logic [DIM_W-1:0]     ROWS_RST   = 5'd1;
	localparam logic [DIM_W-1:0]     COLS_RST   = 5'd1;
	localparam logic [PERIOD_W-1:0]  PERIOD_RST = 24'd16667;
	localparam logic [SPEED_W-1:0]   SPEED_RST  = 16'd256;

	// Mode bits
	localparam int unsigned MODE_LOOP_BIT = 0;
	localparam int unsigned MODE_HIDE_BIT = 1;
	localparam int unsigned MODE_AUTO_BIT = 2;

	// Item fields
	localparam int unsigned ELAPSED_W   = 20;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned FRAME_W     = 8;
	localparam int unsigned COUNT_W     = 9;
	localparam int unsigned COORD_W     = 13;
	localparam int unsigned OUT_TDATA_W = 64;
	localparam int unsigned ACC_W       = 40;

	// Serial arithmetic units
	localparam int unsigned MUL_AW = 24;
	localparam int unsigned MUL_BW = 20;
	localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
	localparam int unsigned DIV_DW = 33;
	localparam int unsigned DIV_VW = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_ROWS    = 3'd0,
		REG_GRID_COLUMNS = 3'd1,
		REG_FRAME_PERIOD = 3'd2,
		REG_PLAY_SPEED   = 3'd3,
		REG_MODE_FLAGS   = 3'd4,
		REG_FIRST_FRAME  = 3'd5,
		REG_LAST_FRAME   = 3'd6,
		REG_TEXTURE_SIZE = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_ACC,
		ST_DIV_N,
		ST_MOD,
		ST_KMUL,
		ST_RECT_GO,
		ST_DIV_FW,
		ST_DIV_FH,
		ST_DIV_ROW,
		ST_MUL_LEFT,
		ST_MUL_TOP,
		ST_DONE
	} state_t;

	// A grid dimension of zero counts as one; large values saturate.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input int unsigned max_g);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > max_g) begin
			r = DIM_W'(max_g);
		end
		return r;
	endfunction

endpackage

// ===== sv/sprite_sheet_frame_animator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_sheet_frame_animator_core
// Flipbook animator: advances a sprite-sheet frame from elapsed time and
// returns the source rectangle of the frame shown.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per tick: tuser is the operation (0 tick,
//   1 restart), tdata[19:0] the microseconds elapsed. Every item gives one
//   result item on m_axis with the frame index, the source rectangle and
//   the playing, hide and frame-changed flags.
//   The user must write registers through cfg_write/cfg_index/cfg_data
//   only while the block is idle, which the block does not enforce; a
//   write takes effect at the next clock edge. One item is worked on at
//   a time. Products and quotients of an item are formed by one serial
//   multiplier and one serial divider; the divider is used three times
//   for the rectangle and up to twice for the advance.
//   A finished result sits in an output register, so the next item is
//   accepted while the receiver stalls; the block then waits before
//   delivering the following result until that register is taken.
//   Reset restores the register defaults, stops playback at frame zero and
//   empties the output register.
// ---------------------------------------------------------------------------
module sprite_sheet_frame_animator_core #(
	parameter int unsigned MAX_GRID    = ssfa_pkg::MAX_GRID_DEF,
	parameter int unsigned MAX_TEXTURE = ssfa_pkg::MAX_TEXTURE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_write,
	input  logic [ssfa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ssfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // elapsed_us[19:0], zero pad
	input  logic                             s_axis_tuser,  // operation
	// result items
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// frame_index[7:0], rect_left[20:8], rect_top[33:21], rect_right[46:34],
	// rect_bottom[59:47], is_playing[60], hide_request[61], frame_changed[62], pad
	output logic [ssfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ssfa_pkg::*;

	localparam int unsigned TEX_W  = $clog2(MAX_TEXTURE + 1);
	localparam int unsigned GRID_W = 2 * DIM_W;

	// Configuration registers
	logic [DIM_W-1:0]     rows_q;
	logic [DIM_W-1:0]     cols_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [MODE_W-1:0]    mode_q;
	logic [FIRST_W-1:0]   first_q;
	logic [LAST_W-1:0]    last_q;
	logic [TEX_REG_W-1:0] tex_q;

	// Play state
	state_t             state_q, state_d;
	logic               playing_q;
	logic [FRAME_W-1:0] fc_q;
	logic [ACC_W-1:0]   acc_q;
	logic               changed_q;
	logic               hide_q;

	// Item and working registers
	logic                 op_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [COORD_W-1:0]   fw_q;
	logic [COORD_W-1:0]   fh_q;
	logic [FRAME_W-1:0]   row_q;
	logic [COORD_W-1:0]   left_q;
	logic [COORD_W-1:0]   top_q;
	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// Arithmetic units
	logic              mul_start, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_prod;
	logic              div_start, div_done;
	logic [DIV_DW-1:0] div_dividend, div_quot;
	logic [DIV_VW-1:0] div_divisor, div_rem;

	ssfa_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ssfa_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Playable range from the registers
	logic [DIM_W-1:0]   rows_e, cols_e;
	logic [GRID_W-1:0]  grid_raw;
	logic [COUNT_W-1:0] grid, avail, m_frames, m_minus1;
	logic [FRAME_W-1:0] offset, fc_clamped, abs_frame;
	logic [TEX_W-1:0]   tex_w, tex_h;

	assign rows_e   = eff_dim(rows_q, MAX_GRID);
	assign cols_e   = eff_dim(cols_q, MAX_GRID);
	assign grid_raw = GRID_W'(rows_e) * GRID_W'(cols_e);
	assign grid     = (grid_raw > GRID_W'(256)) ? COUNT_W'(256) : grid_raw[COUNT_W-1:0];
	assign avail    = (last_q != '0 && last_q <= grid) ? last_q : grid;
	assign offset   = (first_q != '0 && {1'b0, first_q} < avail) ? first_q : '0;
	assign m_frames = avail - {1'b0, offset};
	assign m_minus1 = m_frames - COUNT_W'(1);
	assign fc_clamped = ({1'b0, fc_q} >= m_frames) ? m_minus1[FRAME_W-1:0] : fc_q;
	assign abs_frame  = offset + fc_q;

	assign tex_w = (32'(tex_q[15:0]) > MAX_TEXTURE) ? TEX_W'(MAX_TEXTURE)
		: TEX_W'(tex_q[15:0]);
	assign tex_h = (32'(tex_q[31:16]) > MAX_TEXTURE) ? TEX_W'(MAX_TEXTURE)
		: TEX_W'(tex_q[31:16]);

	// Advance arithmetic
	logic             frozen;
	logic [ACC_W-1:0] acc_sum;
	logic [31:0]      n_adv;
	logic [DIV_DW-1:0] fc_plus_n;
	logic             reach_end;
	logic [ACC_W-1:0] acc_rem;
	logic [COUNT_W-1:0] k_left;
	logic             out_free;

	assign frozen    = !playing_q || m_frames <= COUNT_W'(1) || period_q == '0 || speed_q == '0;
	assign acc_sum   = acc_q + ACC_W'(mul_prod);
	assign n_adv     = div_quot[31:0];
	assign fc_plus_n = {1'b0, n_adv} + DIV_DW'(fc_q);
	assign reach_end = fc_plus_n >= DIV_DW'(m_frames);
	assign acc_rem   = {8'd0, div_rem, acc_q[7:0]};
	assign k_left    = m_frames - COUNT_W'(fc_q);
	assign out_free  = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			period_q <= PERIOD_RST;
			speed_q  <= SPEED_RST;
			mode_q   <= '0;
			first_q  <= '0;
			last_q   <= '0;
			tex_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS:    rows_q   <= cfg_data[DIM_W-1:0];
				REG_GRID_COLUMNS: cols_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_PLAY_SPEED:   speed_q  <= cfg_data[SPEED_W-1:0];
				REG_MODE_FLAGS:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_FIRST_FRAME:  first_q  <= cfg_data[FIRST_W-1:0];
				REG_LAST_FRAME:   last_q   <= cfg_data[LAST_W-1:0];
				REG_TEXTURE_SIZE: tex_q    <= cfg_data[TEX_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and arithmetic unit commands
	always_comb begin
		state_d      = state_q;
		mul_start    = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if (op_q || frozen) begin
					state_d = ST_RECT_GO;
				end else begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(speed_q);
					mul_b     = MUL_BW'(elapsed_q);
					state_d   = ST_MUL_ACC;
				end
			end
			ST_MUL_ACC: begin
				if (mul_done) begin
					// Accumulator is in 1/256 us; dropping the low byte lets the
					// divisor be the period in whole microseconds.
					div_start    = 1'b1;
					div_dividend = {1'b0, acc_sum[ACC_W-1:8]};
					div_divisor  = DIV_VW'(period_q);
					state_d      = ST_DIV_N;
				end
			end
			ST_DIV_N: begin
				if (div_done) begin
					if (n_adv == '0) begin
						state_d = ST_RECT_GO;
					end else if (mode_q[MODE_LOOP_BIT]) begin
						div_start    = 1'b1;
						div_dividend = fc_plus_n;
						div_divisor  = DIV_VW'(m_frames);
						state_d      = ST_MOD;
					end else if (reach_end) begin
						mul_start = 1'b1;
						mul_a     = MUL_AW'(period_q);
						mul_b     = MUL_BW'(k_left);
						state_d   = ST_KMUL;
					end else begin
						state_d = ST_RECT_GO;
					end
				end
			end
			ST_MOD: begin
				if (div_done) begin
					state_d = ST_RECT_GO;
				end
			end
			ST_KMUL: begin
				if (mul_done) begin
					state_d = ST_RECT_GO;
				end
			end
			ST_RECT_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(tex_w);
				div_divisor  = DIV_VW'(cols_e);
				state_d      = ST_DIV_FW;
			end
			ST_DIV_FW: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_DW'(tex_h);
					div_divisor  = DIV_VW'(rows_e);
					state_d      = ST_DIV_FH;
				end
			end
			ST_DIV_FH: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_DW'(abs_frame);
					div_divisor  = DIV_VW'(cols_e);
					state_d      = ST_DIV_ROW;
				end
			end
			ST_DIV_ROW: begin
				if (div_done) begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(fw_q);
					mul_b     = MUL_BW'(div_rem[DIM_W-1:0]);
					state_d   = ST_MUL_LEFT;
				end
			end
			ST_MUL_LEFT: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(fh_q);
					mul_b     = MUL_BW'(row_q);
					state_d   = ST_MUL_TOP;
				end
			end
			ST_MUL_TOP: begin
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Play state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			fc_q      <= '0;
			acc_q     <= '0;
			changed_q <= 1'b0;
			hide_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_PREP: begin
					changed_q <= 1'b0;
					hide_q    <= 1'b0;
					if (op_q) begin
						playing_q <= mode_q[MODE_AUTO_BIT];
						fc_q      <= '0;
						acc_q     <= '0;
					end else begin
						fc_q <= fc_clamped;
					end
				end
				ST_MUL_ACC: begin
					if (mul_done) begin
						acc_q <= acc_sum;
					end
				end
				ST_DIV_N: begin
					if (div_done && n_adv != '0) begin
						changed_q <= 1'b1;
						if (mode_q[MODE_LOOP_BIT]) begin
							acc_q <= acc_rem;
						end else if (reach_end) begin
							// Stop on the last frame; only the periods used are spent.
							fc_q      <= m_minus1[FRAME_W-1:0];
							playing_q <= 1'b0;
							hide_q    <= mode_q[MODE_HIDE_BIT];
						end else begin
							fc_q  <= fc_plus_n[FRAME_W-1:0];
							acc_q <= acc_rem;
						end
					end
				end
				ST_MOD: begin
					if (div_done) begin
						fc_q <= div_rem[FRAME_W-1:0];
					end
				end
				ST_KMUL: begin
					if (mul_done) begin
						acc_q <= acc_q - {mul_prod[31:0], 8'd0};
					end
				end
				default: ;
			endcase
		end
	end

	// Item capture and rectangle working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			op_q      <= s_axis_tuser;
			elapsed_q <= s_axis_tdata[ELAPSED_W-1:0];
		end
		if (state_q == ST_DIV_FW && div_done) begin
			fw_q <= div_quot[COORD_W-1:0];
		end
		if (state_q == ST_DIV_FH && div_done) begin
			fh_q <= div_quot[COORD_W-1:0];
		end
		if (state_q == ST_DIV_ROW && div_done) begin
			row_q <= div_quot[FRAME_W-1:0];
		end
		if (state_q == ST_MUL_LEFT && mul_done) begin
			left_q <= mul_prod[COORD_W-1:0];
		end
		if (state_q == ST_MUL_TOP && mul_done) begin
			top_q <= mul_prod[COORD_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {1'b0, changed_q, hide_q, playing_q,
				COORD_W'(top_q + fh_q), COORD_W'(left_q + fw_q),
				top_q, left_q, abs_frame};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== sv/ssfa_serial_mul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfa_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// ---------------------------------------------------------------------------
module ssfa_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssfa_pkg::MUL_AW-1:0] a,
	input  logic [ssfa_pkg::MUL_BW-1:0] b,
	output logic                        done,
	output logic [ssfa_pkg::MUL_PW-1:0] prod
);
	import ssfa_pkg::*;

	localparam int unsigned CNT_W = $clog2(MUL_BW);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_PW-1:0] prod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= {prod_q[MUL_PW-2:0], 1'b0} + (b_q[MUL_BW-1] ? MUL_PW'(a_q) : '0);
			b_q    <= {b_q[MUL_BW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== sv/ssfa_serial_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssfa_serial_div
// Restoring divider, one quotient bit per cycle, giving quotient and
// remainder.
// ---------------------------------------------------------------------------
module ssfa_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ssfa_pkg::DIV_DW-1:0] dividend,
	input  logic [ssfa_pkg::DIV_VW-1:0] divisor,
	output logic                        done,
	output logic [ssfa_pkg::DIV_DW-1:0] quot,
	output logic [ssfa_pkg::DIV_VW-1:0] rem
);
	import ssfa_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIV_DW);

	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_VW:0]   rem_sh;
	logic [DIV_VW:0]   diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_DW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits DIV_VW bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
			quo_q <= {quo_q[DIV_DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
